[src/mbm_pkg.sv]
// ----------------------------------------------------------------------------
// mbm_pkg: shared types and constants for the motif best-match scorer
// Sizes, register codes, queue entry and divider handshake structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbm_pkg;

  localparam int MOTIF_MAX     = 32;
  localparam int MAX_SEQUENCES = 1024;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 1;
  localparam int LEN_W     = 6;
  localparam int BASE_W    = 2;
  localparam int MI_W      = $clog2(MOTIF_MAX);
  localparam int HIT_W     = 6;
  localparam int CNT_W     = 11;
  localparam int TOTAL_W   = 16;
  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = TOTAL_W + FRAC_BITS;
  localparam int DEN_W     = 16;
  localparam int MEAN_W    = 17;
  localparam int DIV_CW    = $clog2(NUM_W);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOTIF_BASES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTIF_LEN   = 1'b1;

  typedef struct packed {
    logic [MOTIF_MAX-1:0] hit_mask;
    logic                 seq_end;
    logic                 set_end;
    logic [LEN_W-1:0]     len;
  } mbm_entry_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [Q_CW-1:0] count;
  } mbm_qstat_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } mbm_div_req_t;

  typedef struct packed {
    logic              idle;
    logic              done;
    logic [MEAN_W-1:0] quot;
  } mbm_div_stat_t;

endpackage

[src/mbm_front.sv]
// ----------------------------------------------------------------------------
// mbm_front: base window and motif compare
// Shifts accepted bases into the window and queues the per-position hit mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbm_front import mbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BASE_W-1:0] in_base_code,
  input  logic              in_sequence_end,
  input  logic              in_set_end,
  input  logic [CFG_W-1:0]  motif_bases,
  input  logic [LEN_W-1:0]  eff_len,
  input  mbm_qstat_t        q_stat,
  output logic              push,
  output mbm_entry_t        entry
);

  logic [MOTIF_MAX-1:0][BASE_W-1:0] window_r;
  logic [MOTIF_MAX-1:0][BASE_W-1:0] window_nxt;
  logic [LEN_W-1:0]                 fill_r;
  logic [LEN_W-1:0]                 fill_inc;
  logic                             cmp_ok;
  logic                             seq_end_any;
  logic [MOTIF_MAX-1:0]             hit_mask;

  assign in_ready    = !q_stat.full;
  assign push        = in_valid && in_ready;
  assign seq_end_any = in_sequence_end || in_set_end;
  assign fill_inc    = (fill_r < LEN_W'(MOTIF_MAX)) ? fill_r + LEN_W'(1) : fill_r;
  assign cmp_ok      = fill_inc >= eff_len;

  // window after this base: index 0 is the newest
  always_comb begin
    window_nxt[0] = in_base_code;
    for (int k = 1; k < MOTIF_MAX; k++) begin
      window_nxt[k] = window_r[k-1];
    end
  end

  // position k of the window lines up with motif base len-1-k
  always_comb begin
    logic [LEN_W-1:0]  mi;
    logic [BASE_W-1:0] mbase;
    for (int k = 0; k < MOTIF_MAX; k++) begin
      mi          = eff_len - LEN_W'(k) - LEN_W'(1);
      mbase       = motif_bases[{mi[MI_W-1:0], 1'b0} +: BASE_W];
      hit_mask[k] = cmp_ok && (LEN_W'(k) < eff_len) && (window_nxt[k] == mbase);
    end
  end

  assign entry.hit_mask = hit_mask;
  assign entry.seq_end  = seq_end_any;
  assign entry.set_end  = in_set_end;
  assign entry.len      = eff_len;

  always_ff @(posedge clk) begin
    if (push) begin
      window_r <= window_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (push) begin
      fill_r <= seq_end_any ? '0 : fill_inc;
    end
  end

endmodule

[src/mbm_queue.sv]
// ----------------------------------------------------------------------------
// mbm_queue: short FIFO between front and back
// Register-based, head entry presented combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbm_queue import mbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  mbm_entry_t push_entry,
  input  logic       pop,
  output mbm_entry_t head,
  output mbm_qstat_t stat
);

  mbm_entry_t      mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] count_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = count_r == Q_CW'(Q_DEPTH);
  assign stat.empty = count_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + Q_CW'(1);
        2'b01:   count_r <= count_r - Q_CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[src/mbm_div.sv]
// ----------------------------------------------------------------------------
// mbm_div: restoring divider for the set mean
// One quotient bit per cycle; result held until acknowledged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbm_div import mbm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  mbm_div_req_t  req,
  input  logic          ack,
  output mbm_div_stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_r,  state_nxt;
  logic [DIV_CW-1:0] step_r,   step_nxt;
  logic [DEN_W-1:0]  rem_r,    rem_nxt;
  logic [NUM_W-1:0]  quo_r,    quo_nxt;
  logic [DEN_W-1:0]  den_r,    den_nxt;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          state_nxt = S_RUN;
          step_nxt  = '0;
          rem_nxt   = '0;
          quo_nxt   = req.num;
          den_nxt   = req.den;
        end
      end
      S_RUN: begin
        // remainder stays below the divisor, so the low bits suffice
        rem_nxt  = fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        quo_nxt  = {quo_r[NUM_W-2:0], fits};
        step_nxt = step_r + DIV_CW'(1);
        if (step_r == DIV_CW'(NUM_W - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (ack) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
  end

  assign stat.idle = state_r == S_IDLE;
  assign stat.done = state_r == S_DONE;
  assign stat.quot = quo_r[MEAN_W-1:0];

endmodule

[src/mbm_back.sv]
// ----------------------------------------------------------------------------
// mbm_back: hit counting, per-sequence best, set totals and result register
// Popcount stage, accumulate stage, mean divider, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbm_back import mbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mbm_entry_t        head,
  input  mbm_qstat_t        q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HIT_W-1:0]  out_sequence_best,
  output logic              out_set_done,
  output logic [MEAN_W-1:0] out_mean_score_q16,
  output logic [CNT_W-1:0]  out_sequences_seen
);

  function automatic logic [HIT_W-1:0] popcount(input logic [MOTIF_MAX-1:0] v);
    logic [HIT_W-1:0] s;
    s = '0;
    for (int i = 0; i < MOTIF_MAX; i++) begin
      s = s + HIT_W'(v[i]);
    end
    return s;
  endfunction

  // popcount stage
  logic             s1_valid_r;
  logic [HIT_W-1:0] s1_hits_r;
  logic             s1_seq_end_r;
  logic             s1_set_end_r;
  logic [LEN_W-1:0] s1_len_r;

  // accumulators
  logic [HIT_W-1:0]   best_r;
  logic [TOTAL_W-1:0] total_r;
  logic [CNT_W-1:0]   count_r;
  logic [HIT_W-1:0]   pend_best_r;
  logic [CNT_W-1:0]   pend_cnt_r;

  // result register
  logic              out_valid_r;
  logic [HIT_W-1:0]  out_best_r;
  logic              out_done_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic [CNT_W-1:0]  out_seen_r;

  logic               out_free;
  logic               s2_take;
  logic               s1_free;
  logic [HIT_W-1:0]   best_fin;
  logic               cnt_ok;
  logic [CNT_W-1:0]   cnt_new;
  logic [TOTAL_W-1:0] tot_new;
  logic [LEN_W+CNT_W-1:0] den_full;
  logic               load_seq;
  logic               load_set;
  mbm_div_req_t       div_req;
  mbm_div_stat_t      div_stat;

  assign out_free = !out_valid_r || out_ready;
  assign s2_take  = s1_valid_r && div_stat.idle &&
                    (!s1_seq_end_r || s1_set_end_r || out_free);
  assign s1_free  = !s1_valid_r || s2_take;
  assign pop      = !q_stat.empty && s1_free;

  assign best_fin = (s1_hits_r > best_r) ? s1_hits_r : best_r;
  assign cnt_ok   = count_r < CNT_W'(MAX_SEQUENCES);
  assign cnt_new  = cnt_ok ? count_r + CNT_W'(1) : count_r;
  assign tot_new  = cnt_ok ? total_r + TOTAL_W'(best_fin) : total_r;
  assign den_full = (LEN_W+CNT_W)'(s1_len_r) * (LEN_W+CNT_W)'(cnt_new);

  assign load_seq = s2_take && s1_seq_end_r && !s1_set_end_r;
  assign load_set = div_stat.done && out_free;

  assign div_req.start = s2_take && s1_set_end_r;
  assign div_req.num   = {tot_new, FRAC_BITS'(0)};
  assign div_req.den   = den_full[DEN_W-1:0];

  mbm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .ack   (load_set),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_hits_r    <= popcount(head.hit_mask);
      s1_seq_end_r <= head.seq_end;
      s1_set_end_r <= head.set_end;
      s1_len_r     <= head.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r  <= '0;
      total_r <= '0;
      count_r <= '0;
    end else if (s2_take) begin
      if (!s1_seq_end_r) begin
        best_r <= best_fin;
      end else begin
        best_r <= '0;
        if (s1_set_end_r) begin
          total_r <= '0;
          count_r <= '0;
        end else begin
          total_r <= tot_new;
          count_r <= cnt_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_req.start) begin
      pend_best_r <= best_fin;
      pend_cnt_r  <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_seq || load_set) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_seq) begin
      out_best_r <= best_fin;
      out_done_r <= 1'b0;
      out_mean_r <= '0;
      out_seen_r <= cnt_new;
    end else if (load_set) begin
      out_best_r <= pend_best_r;
      out_done_r <= 1'b1;
      out_mean_r <= div_stat.quot;
      out_seen_r <= pend_cnt_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sequence_best  = out_best_r;
  assign out_set_done       = out_done_r;
  assign out_mean_score_q16 = out_mean_r;
  assign out_sequences_seen = out_seen_r;

endmodule

[src/motif_best_match_scorer.sv]
// ----------------------------------------------------------------------------
// motif_best_match_scorer: best Hamming match of a motif over DNA sequences
// Usage:
//   cfg_*  : write motif_bases (index 0) and the motif length (index 1) while idle.
//   in_*   : one base per transfer; sequence_end / set_end tag the last base.
//   out_*  : one result per sequence end: best count, sequences seen, and on
//            set end the mean matched fraction in Q1.16 (set_done = 1).
// Throughput: one base per cycle while the front queue has room.
// A set end holds the back end while the restoring divider produces
// one quotient bit per cycle; bases keep flowing into the 4-entry
// queue meanwhile and then stall.
// A sequence result passes from the queue through the popcount stage into the
// result register; a set result also passes through the mean divider first.
// Reset (synchronous, rst_n low): motif_bases = 0, motif length = 3, queue,
// counters and result register empty.
// Receiver stall: the result register holds; the back end stops at the next
// sequence end, the queue fills and in_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motif_best_match_scorer import mbm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BASE_W-1:0]    in_base_code,
  input  logic                 in_sequence_end,
  input  logic                 in_set_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [HIT_W-1:0]     out_sequence_best,
  output logic                 out_set_done,
  output logic [MEAN_W-1:0]    out_mean_score_q16,
  output logic [CNT_W-1:0]     out_sequences_seen
);

  logic [CFG_W-1:0] motif_bases_r;
  logic [LEN_W-1:0] motif_len_r;
  logic [LEN_W-1:0] eff_len;

  logic       push;
  logic       pop;
  mbm_entry_t push_entry;
  mbm_entry_t head;
  mbm_qstat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motif_bases_r <= '0;
      motif_len_r   <= LEN_W'(3);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MOTIF_BASES: motif_bases_r <= cfg_wdata;
        REG_MOTIF_LEN:   motif_len_r   <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero length counts as one, anything above the window saturates
  always_comb begin
    if (motif_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (motif_len_r > LEN_W'(MOTIF_MAX)) begin
      eff_len = LEN_W'(MOTIF_MAX);
    end else begin
      eff_len = motif_len_r;
    end
  end

  mbm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_base_code    (in_base_code),
    .in_sequence_end (in_sequence_end),
    .in_set_end      (in_set_end),
    .motif_bases     (motif_bases_r),
    .eff_len         (eff_len),
    .q_stat          (q_stat),
    .push            (push),
    .entry           (push_entry)
  );

  mbm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  mbm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .q_stat             (q_stat),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sequence_best  (out_sequence_best),
    .out_set_done       (out_set_done),
    .out_mean_score_q16 (out_mean_score_q16),
    .out_sequences_seen (out_sequences_seen)
  );

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= Q_CW'(Q_DEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("push into a full queue");

  a_mean_only_on_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_set_done) |-> (out_mean_score_q16 == '0))
    else $error("mean set on a sequence result");

  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sequences_seen != '0) &&
                  (out_sequences_seen <= CNT_W'(MAX_SEQUENCES)) &&
                  (out_sequence_best <= HIT_W'(MOTIF_MAX)))
    else $error("result fields out of range");
`endif

endmodule

[test/motif_score_checker.sv]
// ----------------------------------------------------------------------------
// motif_score_checker: score prediction and result compare for the scorer
// Follows config writes and base transfers, keeps its own window, best and
// set totals, and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motif_score_checker import mbm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [BASE_W-1:0]    in_base_code,
  input  logic                 in_sequence_end,
  input  logic                 in_set_end,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [HIT_W-1:0]     out_sequence_best,
  input  logic                 out_set_done,
  input  logic [MEAN_W-1:0]    out_mean_score_q16,
  input  logic [CNT_W-1:0]     out_sequences_seen,
  output int                   fail_count,
  output int                   awaited,
  output int                   scores_checked,
  output int                   sets_checked
);

  typedef struct packed {
    logic [HIT_W-1:0]  best;
    logic              done;
    logic [MEAN_W-1:0] mean;
    logic [CNT_W-1:0]  seen;
  } score_t;

  logic [CFG_W-1:0]   motif_q;
  logic [LEN_W-1:0]   length_q;
  logic [BASE_W-1:0]  window [MOTIF_MAX];   // [0] is the newest base
  int unsigned        fill;
  logic [HIT_W-1:0]   best;
  logic [TOTAL_W-1:0] total;
  logic [CNT_W-1:0]   counted;
  score_t             expected_scores [$];
  int                 fails;
  int                 checked;
  int                 closed;

  function automatic int unsigned active_length();
    int unsigned len;
    len = length_q;
    if (len == 0) len = 1;
    if (len > MOTIF_MAX) len = MOTIF_MAX;
    return len;
  endfunction

  function void clear_model();
    motif_q  = '0;
    length_q = LEN_W'(3);
    foreach (window[i]) window[i] = '0;
    fill    = 0;
    best    = '0;
    total   = '0;
    counted = '0;
    expected_scores.delete();
  endfunction

  // shift in one base, update the running best, queue a score on a sequence end
  function void absorb_base(logic [BASE_W-1:0] code, logic seq_flag, logic set_flag);
    int unsigned len;
    int unsigned hits;
    longint unsigned num;
    longint unsigned den;
    score_t s;
    len = active_length();
    for (int i = MOTIF_MAX - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = code;
    if (fill < MOTIF_MAX) fill++;
    if (fill >= len) begin
      hits = 0;
      // motif base 0 lines up with the oldest of the last len bases
      for (int j = 0; j < len; j++)
        if (window[len-1-j] == motif_q[2*j +: 2]) hits++;
      if (hits > best) best = HIT_W'(hits);
    end
    if (!(seq_flag || set_flag)) return;
    if (counted < MAX_SEQUENCES) begin
      counted++;
      total = total + TOTAL_W'(best);
    end
    s.best = best;
    s.done = set_flag;
    s.mean = '0;
    s.seen = counted;
    if (set_flag && counted != 0) begin
      num    = longint'(total) << FRAC_BITS;
      den    = longint'(len) * longint'(counted);
      s.mean = MEAN_W'(num / den);
    end
    expected_scores.push_back(s);
    fill = 0;
    best = '0;
    if (set_flag) begin
      total   = '0;
      counted = '0;
    end
  endfunction

  function void note_failure(string what, score_t want, score_t got);
    fails++;
    if (fails <= 10)
      $display("%0t %s: expected best=%0d done=%0b mean=%0d seen=%0d,",
               $time, what, want.best, want.done, want.mean, want.seen,
               " got best=%0d done=%0b mean=%0d seen=%0d",
               got.best, got.done, got.mean, got.seen);
  endfunction

  initial begin
    fails   = 0;
    checked = 0;
    closed  = 0;
    clear_model();
  end

  always @(posedge clk) begin
    score_t got;
    score_t want;
    if (!rst_n) begin
      clear_model();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MOTIF_BASES: motif_q  = cfg_wdata;
          REG_MOTIF_LEN:   length_q = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        absorb_base(in_base_code, in_sequence_end, in_set_end);
      if (out_valid && out_ready) begin
        got = {out_sequence_best, out_set_done, out_mean_score_q16, out_sequences_seen};
        if (expected_scores.size() == 0) begin
          want = '0;
          note_failure("result with no score pending", want, got);
        end else begin
          want = expected_scores.pop_front();
          checked++;
          if (want.done) closed++;
          if (got !== want) note_failure("score mismatch", want, got);
        end
      end
    end
    fail_count     <= fails;
    awaited        <= expected_scores.size();
    scores_checked <= checked;
    sets_checked   <= closed;
  end

endmodule

[test/motif_best_match_scorer_test.sv]
// ----------------------------------------------------------------------------
// motif_best_match_scorer_test: stimulus and verdict for the motif scorer
// Directed corner sequences, then random phases of motif-like sequences under
// varied motif settings, then one set long enough to overflow the sequence
// count. Sender bursts and receiver stalls are random; the checker compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motif_best_match_scorer_test;
  import mbm_pkg::*;

  localparam int RANDOM_BASES   = 100;   // the overflow set adds about a thousand
  localparam int OVERFLOW_SEQS  = MAX_SEQUENCES + 12;
  localparam int SETTLE_CYCLES  = 60;    // queue + divider, with margin
  localparam int QUIET_LIMIT    = 2000;  // cycles with no transfer at all

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MOTIF_BASES;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BASE_W-1:0]    in_base_code = '0;
  logic                 in_sequence_end = 1'b0;
  logic                 in_set_end = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [HIT_W-1:0]     out_sequence_best;
  logic                 out_set_done;
  logic [MEAN_W-1:0]    out_mean_score_q16;
  logic [CNT_W-1:0]     out_sequences_seen;

  int       fail_count;
  int       awaited;
  int       scores_checked;
  int       sets_checked;
  rx_mode_t rx_mode = RX_CHOPPY;
  int       ready_run = 0;
  int       quiet_cycles = 0;
  int       burst_left = 0;
  int       gap_max = 0;
  int       bases_sent = 0;

  always #10 clk = ~clk;

  motif_best_match_scorer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_base_code       (in_base_code),
    .in_sequence_end    (in_sequence_end),
    .in_set_end         (in_set_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sequence_best  (out_sequence_best),
    .out_set_done       (out_set_done),
    .out_mean_score_q16 (out_mean_score_q16),
    .out_sequences_seen (out_sequences_seen)
  );

  motif_score_checker score_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_base_code       (in_base_code),
    .in_sequence_end    (in_sequence_end),
    .in_set_end         (in_set_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sequence_best  (out_sequence_best),
    .out_set_done       (out_set_done),
    .out_mean_score_q16 (out_mean_score_q16),
    .out_sequences_seen (out_sequences_seen),
    .fail_count         (fail_count),
    .awaited            (awaited),
    .scores_checked     (scores_checked),
    .sets_checked       (sets_checked)
  );

  // Result side: alternating ready/stall runs. Open mode never stalls,
  // choppy mode stalls a few cycles, slow mode holds off long enough to
  // back the queue up into in_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_run <= 0;
    end else if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else if (rx_mode == RX_OPEN) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= !out_ready;
      if (out_ready)
        ready_run <= (rx_mode == RX_SLOW) ? $urandom_range(5, 40) : $urandom_range(0, 3);
      else
        ready_run <= $urandom_range(0, 12);
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d scores still pending",
                 quiet_cycles, awaited);
        $display("[motif_best_match_scorer] ERROR");
        $finish;
      end
    end
  end

  // One base transfer. Bursts of random length; a burst may open with a gap.
  // Called on a clock edge, returns on the edge of its transfer.
  task automatic send_base(input logic [BASE_W-1:0] code, input logic seq_flag,
                           input logic set_flag);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_base_code    <= code;
    in_sequence_end <= seq_flag;
    in_set_end      <= set_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bases_sent++;
  endtask

  // Drop valid, wait out every pending score, then let the pipe run dry.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly a mutated copy of the motif between random flanks; now and then a
  // short random run, which is often shorter than the motif. left_open
  // leaves the sequence unfinished so the next phase continues it.
  task automatic send_sequence(input logic [CFG_W-1:0] motif, input int span,
                               input bit closes_set, input bit left_open);
    logic [BASE_W-1:0] body [$];
    int prefix;
    int flips;
    logic seq_flag;
    logic set_flag;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, span + 2)) body.push_back(BASE_W'($urandom_range(0, 3)));
    end else begin
      prefix = $urandom_range(0, 5);
      repeat (prefix) body.push_back(BASE_W'($urandom_range(0, 3)));
      for (int k = 0; k < span; k++) body.push_back(motif[2*k +: 2]);
      flips = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
      repeat (flips) body[prefix + $urandom_range(0, span - 1)] = BASE_W'($urandom_range(0, 3));
      repeat ($urandom_range(0, 5)) body.push_back(BASE_W'($urandom_range(0, 3)));
    end
    foreach (body[k]) begin
      seq_flag = 1'b0;
      set_flag = 1'b0;
      if (!left_open && k == body.size() - 1) begin
        // a set end also ends the sequence, with or without its own flag
        set_flag = closes_set;
        seq_flag = closes_set ? 1'($urandom_range(0, 1)) : 1'b1;
      end
      send_base(body[k], seq_flag, set_flag);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] motif_now;
    logic [CFG_W-1:0] len_word;
    int               span_now;
    int               start_count;
    int               pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed corners ----
    gap_max = 2;
    // reset motif is all base 0, length 3: exact match, then a short sequence
    send_base(2'd0, 1'b0, 1'b0);
    send_base(2'd0, 1'b0, 1'b0);
    send_base(2'd0, 1'b1, 1'b0);
    send_base(2'd2, 1'b1, 1'b0);
    // set end without the sequence end flag
    send_base(2'd0, 1'b0, 1'b0);
    send_base(2'd0, 1'b0, 1'b0);
    send_base(2'd0, 1'b0, 1'b0);
    send_base(2'd0, 1'b0, 1'b1);
    settle();
    // length zero acts as one; single-sequence set with a perfect mean
    write_reg(REG_MOTIF_LEN, '0);
    write_reg(REG_MOTIF_BASES, 64'hC000_0000_0000_0003);
    send_base(2'd3, 1'b1, 1'b1);
    // a set of misses: mean of zero
    send_base(2'd1, 1'b1, 1'b0);
    send_base(2'd2, 1'b0, 1'b1);
    settle();
    // oversized length saturates at the window size
    write_reg(REG_MOTIF_LEN, 64'd63);
    write_reg(REG_MOTIF_BASES, '1);
    send_base(2'd3, 1'b0, 1'b0);
    send_base(2'd3, 1'b0, 1'b0);
    send_base(2'd3, 1'b0, 1'b0);
    send_base(2'd3, 1'b0, 1'b0);
    send_base(2'd3, 1'b1, 1'b0);
    settle();
    // only the low six bits of the length word count
    write_reg(REG_MOTIF_LEN, 64'hFFFF_FFFF_FFFF_FFC2);
    send_base(2'd1, 1'b0, 1'b0);
    send_base(2'd3, 1'b0, 1'b0);
    send_base(2'd3, 1'b0, 1'b0);
    // length change in the middle of a sequence
    settle();
    write_reg(REG_MOTIF_LEN, 64'd1);
    send_base(2'd0, 1'b0, 1'b0);
    send_base(2'd3, 1'b1, 1'b1);

    // ---- random phases, each under its own motif setting ----
    start_count = bases_sent;
    motif_now   = '1;
    span_now    = 1;
    while (bases_sent - start_count < RANDOM_BASES) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 5);
        motif_now = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom(), $urandom()};
        write_reg(REG_MOTIF_BASES, motif_now);
      end
      if ($urandom_range(0, 3) != 0) begin
        len_word = {$urandom(), $urandom()};
        pick = $urandom_range(0, 9);
        case (pick)
          0:       len_word[LEN_W-1:0] = '0;
          1:       len_word[LEN_W-1:0] = LEN_W'(MOTIF_MAX);
          2:       len_word[LEN_W-1:0] = LEN_W'($urandom_range(MOTIF_MAX + 1, 63));
          3:       len_word[LEN_W-1:0] = LEN_W'(1);
          default: len_word[LEN_W-1:0] = LEN_W'($urandom_range(2, 12));
        endcase
        span_now = int'(len_word[LEN_W-1:0]);
        if (span_now == 0) span_now = 1;
        if (span_now > MOTIF_MAX) span_now = MOTIF_MAX;
        write_reg(REG_MOTIF_LEN, len_word);
      end
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      pick    = $urandom_range(0, 2);
      gap_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 12;
      repeat ($urandom_range(2, 8))
        send_sequence(motif_now, span_now, $urandom_range(0, 5) == 0, 1'b0);
      if ($urandom_range(0, 3) == 0)
        send_sequence(motif_now, span_now, 1'b0, 1'b1);
    end

    // ---- one set with more sequences than the counter holds ----
    settle();
    write_reg(REG_MOTIF_LEN, 64'd1);
    write_reg(REG_MOTIF_BASES, {$urandom(), $urandom()});
    rx_mode <= RX_CHOPPY;
    gap_max = 3;
    send_base(BASE_W'($urandom_range(0, 3)), 1'b0, 1'b1);  // close any open set
    for (int n = 0; n < OVERFLOW_SEQS; n++)
      send_base(BASE_W'($urandom_range(0, 3)), 1'b1, n == OVERFLOW_SEQS - 1);

    settle();
    $display("%0d bases in, %0d sequence scores checked, %0d of them closing a set",
             bases_sent, scores_checked, sets_checked);
    $display("directed length corners, random motif phases, one set of %0d past the cap",
             OVERFLOW_SEQS);
    if (fail_count == 0)
      $display("[motif_best_match_scorer] OK");
    else
      $display("[motif_best_match_scorer] ERROR");
    $finish;
  end

endmodule
